// ===== sv/wud_pkg.sv =====
// Shared constants, payload structs and sequencer states for the 128-bit divider.
package wud_pkg;

	localparam int FIELD_W = 64;
	localparam int FULL_W  = 2 * FIELD_W;
	localparam int WIDTH   = 128;
	localparam int CNT_W   = $clog2(WIDTH);

	typedef struct packed {
		logic [FIELD_W-1:0] dividend_lo;
		logic [FIELD_W-1:0] dividend_hi;
		logic [FIELD_W-1:0] divisor_lo;
		logic [FIELD_W-1:0] divisor_hi;
	} operands_t;

	typedef struct packed {
		logic [FIELD_W-1:0] quotient_lo;
		logic [FIELD_W-1:0] quotient_hi;
		logic [FIELD_W-1:0] remainder_lo;
		logic [FIELD_W-1:0] remainder_hi;
		logic               divide_by_zero;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

endpackage

// ===== sv/wud_step.sv =====
// One radix-2 division step: shift in a dividend bit, trial subtract, retire a quotient bit.
module wud_step (
	input  logic [wud_pkg::WIDTH-1:0] rem,
	input  logic [wud_pkg::WIDTH-1:0] nq,
	input  logic [wud_pkg::WIDTH-1:0] div,
	output logic [wud_pkg::WIDTH-1:0] rem_nx,
	output logic [wud_pkg::WIDTH-1:0] nq_nx
);
	import wud_pkg::*;

	logic [WIDTH:0] shifted;
	logic [WIDTH:0] diff;
	logic           ge;

	// nq holds the unconsumed dividend bits on top and the quotient bits below
	assign shifted = {rem, nq[WIDTH-1]};
	assign diff    = shifted - {1'b0, div};
	assign ge      = ~diff[WIDTH];

	assign rem_nx = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
	assign nq_nx  = {nq[WIDTH-2:0], ge};

endmodule

// ===== sv/wide_unsigned_divider_128.sv =====
// Top level of the iterative 128-bit unsigned divider.
//
// Usage:
//   Drive operands and raise start; the beat is taken at a clock edge where
//   start is high and busy is low. busy stays high while the division runs.
//   The quotient and remainder appear on result, marked by done, which is high
//   for exactly one cycle. The receiver has no way to hold a result off.
// Iteration:
//   A nonzero divisor keeps busy high while the steps run, one quotient bit per
//   cycle through the shared subtract/compare step unit; done rises in the
//   cycle after the last step. A new item may be started in that cycle, but
//   none is taken while a division still runs.
//   A zero divisor skips the iteration: done rises the cycle after the
//   beat, with divide_by_zero set, quotient zero and remainder the dividend.
// Reset:
//   arst_n clears the sequencer and done; no result is pending after reset.
module wide_unsigned_divider_128 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  wud_pkg::operands_t operands,
	output logic               done,
	output wud_pkg::result_t   result
);
	import wud_pkg::*;

	state_t           state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q, nq_q, div_q;
	logic [WIDTH-1:0] rem_nx, nq_nx;
	logic [WIDTH-1:0] dividend_in, divisor_in;
	logic [FULL_W-1:0] q_full, r_full, n_full;
	logic             accept, last, div_zero;
	logic             done_q;
	result_t          result_q;

	assign dividend_in = WIDTH'({operands.dividend_hi, operands.dividend_lo});
	assign divisor_in  = WIDTH'({operands.divisor_hi, operands.divisor_lo});
	assign div_zero    = (divisor_in == '0);
	assign accept      = start && !busy;
	assign last        = (cnt_q == '0);

	wud_step u_step (
		.rem    (rem_q),
		.nq     (nq_q),
		.div    (div_q),
		.rem_nx (rem_nx),
		.nq_nx  (nq_nx)
	);

	assign q_full = FULL_W'(nq_nx);
	assign r_full = FULL_W'(rem_nx);
	assign n_full = FULL_W'(dividend_in);

	always_comb begin
		state_nx = state_q;
		busy     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && !div_zero) begin
					state_nx = ST_RUN;
				end
			end
			ST_RUN: begin
				busy = 1'b1;
				if (last) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= 1'b0;
			if (accept) begin
				cnt_q  <= CNT_W'(WIDTH - 1);
				done_q <= div_zero;
			end else if (state_q == ST_RUN) begin
				cnt_q <= cnt_q - 1'b1;
				done_q <= last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_q <= '0;
			nq_q  <= dividend_in;
			div_q <= divisor_in;
			if (div_zero) begin
				result_q.quotient_lo    <= '0;
				result_q.quotient_hi    <= '0;
				result_q.remainder_lo   <= n_full[FIELD_W-1:0];
				result_q.remainder_hi   <= n_full[FULL_W-1:FIELD_W];
				result_q.divide_by_zero <= 1'b1;
			end
		end else if (state_q == ST_RUN) begin
			rem_q <= rem_nx;
			nq_q  <= nq_nx;
			if (last) begin
				result_q.quotient_lo    <= q_full[FIELD_W-1:0];
				result_q.quotient_hi    <= q_full[FULL_W-1:FIELD_W];
				result_q.remainder_lo   <= r_full[FIELD_W-1:0];
				result_q.remainder_hi   <= r_full[FULL_W-1:FIELD_W];
				result_q.divide_by_zero <= 1'b0;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
